/* sv/pfsc_pkg.sv */
// Shared constants and payload types for the prime filter with running count and sum.
package pfsc_pkg;

   localparam int MAX_ELEMENTS = 4096;
   localparam int VALUE_W      = 32;
   localparam int MAG_W        = VALUE_W - 1;
   localparam int COUNT_W      = 13;
   localparam int SUM_W        = 43;
   localparam int DIVISOR_W    = 16;
   localparam int SQUARE_W     = 32;
   localparam int DIV_STEPS    = MAG_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam int COUNT_LIMIT_INT = (MAX_ELEMENTS < 8191) ? MAX_ELEMENTS : 8191;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_INT);
   localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

   localparam logic [DIVISOR_W-1:0] FIRST_DIVISOR = DIVISOR_W'(3);
   localparam logic [SQUARE_W-1:0]  FIRST_SQUARE  = SQUARE_W'(9);

   typedef struct packed {
      logic signed [VALUE_W-1:0] element_value;
      logic                      last_element;
   } req_type;

   typedef struct packed {
      logic               is_prime;
      logic [COUNT_W-1:0] prime_total;
      logic [SUM_W-1:0]   prime_sum;
      logic               matrix_done;
   } rsp_type;

   // Verdict handed from the primality sequencer to the accumulator.
   typedef struct packed {
      logic             valid;
      logic             is_prime;
      logic [MAG_W-1:0] value;
      logic             last;
   } verdict_type;

endpackage

/* sv/pfsc_div.sv */
// Restoring remainder unit: one quotient bit per cycle, remainder of a 31-bit dividend.
module pfsc_div
   import pfsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic [DIVISOR_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [MAG_W-1:0]     shift_ff, shift_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W:0]   trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, shift_ff[MAG_W-1]};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIV_STEPS - 1);
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so the low bits suffice.
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
         shift_in = {shift_ff[MAG_W-2:0], 1'b0};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a running division");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("division started while one is running");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

endmodule

/* sv/pfsc_prime_test.sv */
// Trial-division sequencer: tries odd divisors up to the square root on the shared divider.
module pfsc_prime_test
   import pfsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  req_type     item,
   output logic        item_ready,
   input  logic        verdict_take,
   output verdict_type verdict
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [MAG_W-1:0]      value_ff, value_in;
   logic                  neg_ff, neg_in;
   logic                  last_ff, last_in;
   logic                  prime_ff, prime_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [SQUARE_W-1:0]   square_ff, square_in;
   logic                  div_start;
   logic                  div_busy;
   logic                  div_done;
   logic [DIVISOR_W-1:0]  div_rem;

   pfsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (value_ff),
      .divisor   (divisor_ff),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      neg_in     = neg_ff;
      last_in    = last_ff;
      prime_in   = prime_ff;
      divisor_in = divisor_ff;
      square_in  = square_ff;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               value_in   = item.element_value[MAG_W-1:0];
               neg_in     = item.element_value[VALUE_W-1];
               last_in    = item.last_element;
               divisor_in = FIRST_DIVISOR;
               square_in  = FIRST_SQUARE;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (neg_ff || value_ff < MAG_W'(2)) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else if (value_ff == MAG_W'(2)) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else if (!value_ff[0]) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else if (square_ff > SQUARE_W'(value_ff)) begin
               // No divisor up to the square root: the value is prime.
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // (d + 2)^2 = d^2 + 4d + 4
                  square_in  = SQUARE_W'(square_ff + {divisor_ff, 2'b00} + SQUARE_W'(4));
                  divisor_in = DIVISOR_W'(divisor_ff + DIVISOR_W'(2));
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (verdict_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff   <= value_in;
      neg_ff     <= neg_in;
      last_ff    <= last_in;
      prime_ff   <= prime_in;
      divisor_ff <= divisor_in;
      square_ff  <= square_in;
   end

   assign item_ready       = (state_ff == ST_IDLE);
   assign verdict.valid    = (state_ff == ST_DONE);
   assign verdict.is_prime = prime_ff;
   assign verdict.value    = value_ff;
   assign verdict.last     = last_ff;

   a_idle_divider_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !div_busy)
      else $error("divider running outside a trial division");

   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (divisor_ff[0] && divisor_ff >= FIRST_DIVISOR))
      else $error("trial divisor not an odd value of three or more");

   a_prime_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && prime_ff) |-> (!neg_ff && value_ff >= MAG_W'(2)))
      else $error("prime verdict for a value below two");

endmodule

/* sv/prime_filter_sum_count.sv */
// Top level: primality sequencer, saturating count and sum, and the result register.
//
// Each item is one signed 32-bit matrix element. The block tests it for primality by
// trial division with odd divisors up to its square root, each remainder taken on one
// shared restoring divider. Negative, small or even values are settled without a
// division; a prime near 2^31 needs roughly 23,170 divisions. The input is not
// ready while an item is under test; a finished result waits in the output register
// so the next item can be taken meanwhile. Each result carries the prime flag, the
// running prime count (saturating at the element limit) and the running prime sum
// (saturating at 2^43-1), this element included; after an item marked last both
// totals clear to zero.
module prime_filter_sum_count
   import pfsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   verdict_type        verdict;
   logic               take;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_next;
   logic [SUM_W-1:0]   sum_next;
   logic [SUM_W:0]     sum_wide;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   pfsc_prime_test u_test (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_valid),
      .item         (req_payload),
      .item_ready   (req_ready),
      .verdict_take (take),
      .verdict      (verdict)
   );

   assign take = verdict.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(verdict.value);
      count_next = count_ff;
      sum_next   = sum_ff;
      if (verdict.is_prime) begin
         if (count_ff < COUNT_LIMIT) begin
            count_next = count_ff + 1'b1;
         end
         // A carry out of the sum means it passed the largest value.
         sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end

      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_in.is_prime    = verdict.is_prime;
         rsp_in.prime_total = count_next;
         rsp_in.prime_sum   = sum_next;
         rsp_in.matrix_done = verdict.last;
         rsp_valid_in       = 1'b1;
         count_in           = verdict.last ? '0 : count_next;
         sum_in             = verdict.last ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("prime count above its limit");

   a_nonprime_keeps_totals: assert property (@(posedge clock) disable iff (reset)
      (take && !verdict.is_prime && !verdict.last) |=> ($stable(count_ff) && $stable(sum_ff)))
      else $error("totals changed on a non-prime item");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (take && verdict.last) |=> (count_ff == '0 && sum_ff == '0))
      else $error("totals not cleared after the last item");

endmodule
